// ----- rtl/core/nrg_pkg.sv -----
package nrg_pkg;

    localparam int ATOM_DEPTH = 64;
    localparam int IDX_W      = $clog2(ATOM_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 32;
    localparam int CHARGE_W   = 7;
    localparam int ZZ_W       = 2 * CHARGE_W;
    localparam int GRAD_W     = 48;
    localparam int ACC_W      = 56;
    localparam int MAG_W      = 31;
    localparam int ROOT_W     = 32;
    localparam int FRAC_SHIFT = 30;
    localparam int UNUM_W     = MAG_W + FRAC_SHIFT;
    localparam int U_W        = 31;
    localparam int PROD_W     = ZZ_W + U_W;
    localparam int STEP_W     = 7;
    // quotient bits produced by the scaled divide, minus one
    localparam int QLAST_NORM = PROD_W + 38 - 1;
    localparam int QLAST_HALF = PROD_W + 36 - 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [CHARGE_W-1:0]       charge;
        logic                      final_atom;
    } atom_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]         atom_index;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [GRAD_W-1:0] grad_z;
        logic                     coincident;
        logic                     last_result;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [CHARGE_W-1:0]       ch;
    } atom_t;

endpackage

// ----- rtl/core/nuclear_repulsion_gradient_core.sv -----
// Nuclear repulsion gradient core.
// Input: one atom per beat, accepted at a clock edge with start high and busy
// low. Each accepted atom is written to the atom memory (atoms beyond 64 are
// dropped). A beat with final_atom set ends the set and raises busy.
// Output: one beat per stored atom in load order, shown on result for one
// cycle with result_valid high; last_result marks the final beat of the set.
// The receiver cannot stall, so results leave as soon as they are ready.
// Loading accepts one atom per cycle. After the final atom the block runs every
// ordered pair through one shared bit-serial datapath: reads, squares and
// square root, then per axis a divide, a multiply and a scaled divide; the
// scaled divide is shorter when the differences are halved, and a coincident
// pair stops after the squares. Each atom also has its own reads, a skip of
// its own index and an emit. The atom memory's single read port and the
// serial dividers limit the speed.
// Reset clears the atom count and the sequencer; memory contents are not
// cleared since only entries written in the current set are read.
module nuclear_repulsion_gradient_core
    import nrg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  atom_in_t item,
    output logic     busy,
    output result_t  result,
    output logic     result_valid
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RDK   = 14'b00000000000010,
        S_LDK   = 14'b00000000000100,
        S_RDL   = 14'b00000000001000,
        S_LDL   = 14'b00000000010000,
        S_SQ    = 14'b00000000100000,
        S_CHK   = 14'b00000001000000,
        S_SQRT  = 14'b00000010000000,
        S_UINIT = 14'b00000100000000,
        S_UDIV  = 14'b00001000000000,
        S_MUL   = 14'b00010000000000,
        S_QDIV  = 14'b00100000000000,
        S_ACC   = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [CNT_W-1:0]   l_reg;
    logic [1:0]         ax_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    atom_t              mem [ATOM_DEPTH];
    atom_t              rd_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;

    atom_t              k_atom_reg;
    logic [MAG_W-1:0]   m_reg [3];
    logic [2:0]         dneg_reg;
    logic               half_reg;
    logic [ZZ_W-1:0]    zz_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        sq_rem_reg;
    logic [63:0]        sq_res_reg;
    logic [63:0]        sq_bit_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [UNUM_W-1:0]  un_reg;
    logic [ROOT_W:0]    urem_reg;
    logic [U_W-1:0]     u_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [64:0]        qrem_reg;
    logic [GRAD_W-1:0]  q_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic               coin_reg;

    // pair difference terms
    logic signed [COORD_W:0] d [3];
    logic [COORD_W-1:0]      mag [3];
    logic                    big;
    logic [MAG_W-1:0]        m_new [3];

    // datapath step terms
    logic [2*MAG_W-1:0] sqr;
    logic [63:0]        sq_try;
    logic               sq_ge;
    logic [63:0]        sq_res_new;
    logic [ROOT_W:0]    ut;
    logic               uge;
    logic               qbit;
    logic [64:0]        qt;
    logic               qge;
    logic [GRAD_W:0]    qn;
    logic [STEP_W-1:0]  qlast;
    logic [CNT_W-1:0]   count_inc;
    logic [GRAD_W-1:0]  sat [3];

    localparam logic [GRAD_W-1:0] TERM_CAP = {1'b1, {(GRAD_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'({1'b0, {(GRAD_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'({1'b1, {(GRAD_W-1){1'b0}}});

    assign busy         = (state_reg != S_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign wr_en     = (state_reg == S_IDLE) && start && (count_reg < CNT_W'(ATOM_DEPTH));
    assign rd_addr   = (state_reg == S_RDK) ? k_reg : l_reg[IDX_W-1:0];
    assign count_inc = count_reg + CNT_W'(wr_en);

    // atom memory: written while loading, read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{x: item.pos_x, y: item.pos_y,
                                          z: item.pos_z, ch: item.charge};
        end
        rd_reg <= mem[rd_addr];
    end

    // form differences, magnitudes and the common halving
    always_comb
    begin
        d[0] = {k_atom_reg.x[COORD_W-1], k_atom_reg.x} - {rd_reg.x[COORD_W-1], rd_reg.x};
        d[1] = {k_atom_reg.y[COORD_W-1], k_atom_reg.y} - {rd_reg.y[COORD_W-1], rd_reg.y};
        d[2] = {k_atom_reg.z[COORD_W-1], k_atom_reg.z} - {rd_reg.z[COORD_W-1], rd_reg.z};
        for (int a = 0; a < 3; a++)
        begin
            mag[a] = d[a][COORD_W] ? COORD_W'(-d[a]) : COORD_W'(d[a]);
        end
        big = mag[0][COORD_W-1] | mag[1][COORD_W-1] | mag[2][COORD_W-1];
        for (int a = 0; a < 3; a++)
        begin
            m_new[a] = big ? mag[a][COORD_W-1:1] : mag[a][MAG_W-1:0];
        end
    end

    // one step of square root and of each divider
    always_comb
    begin
        sqr        = m_reg[ax_reg] * m_reg[ax_reg];
        sq_try     = sq_res_reg + sq_bit_reg;
        sq_ge      = (sq_rem_reg >= sq_try);
        sq_res_new = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);

        ut  = {urem_reg[ROOT_W-1:0], un_reg[UNUM_W-1]};
        uge = (ut >= {1'b0, root_reg});

        qbit  = (cnt_reg < STEP_W'(PROD_W)) ? prod_reg[PROD_W-1] : 1'b0;
        qt    = {qrem_reg[63:0], qbit};
        qge   = (qt >= {1'b0, sum_reg});
        qn    = {q_reg, qge};
        qlast = half_reg ? STEP_W'(QLAST_HALF) : STEP_W'(QLAST_NORM);
    end

    // saturate the sums to the output range
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (acc_reg[a] > SAT_HI)
                sat[a] = SAT_HI[GRAD_W-1:0];
            else if (acc_reg[a] < SAT_LO)
                sat[a] = SAT_LO[GRAD_W-1:0];
            else
                sat[a] = acc_reg[a][GRAD_W-1:0];
        end
    end

    // sequence loads, pairs and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            k_reg            <= '0;
            l_reg            <= '0;
            ax_reg           <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        count_reg <= count_inc;
                        if (item.final_atom)
                        begin
                            k_reg     <= '0;
                            state_reg <= S_RDK;
                        end
                    end
                end
                S_RDK:
                begin
                    state_reg <= S_LDK;
                end
                S_LDK:
                begin
                    l_reg     <= '0;
                    state_reg <= S_RDL;
                end
                S_RDL:
                begin
                    if (l_reg >= count_reg)
                        state_reg <= S_EMIT;
                    else if (l_reg[IDX_W-1:0] == k_reg)
                        l_reg <= l_reg + 1'b1;
                    else
                        state_reg <= S_LDL;
                end
                S_LDL:
                begin
                    ax_reg    <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (ax_reg == 2'd2)
                        state_reg <= S_CHK;
                    else
                        ax_reg <= ax_reg + 1'b1;
                end
                S_CHK:
                begin
                    if (sum_reg == '0)
                    begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= S_RDL;
                    end
                    else
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_bit_reg[0])
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_UINIT;
                    end
                end
                S_UINIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_UDIV;
                end
                S_UDIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == STEP_W'(UNUM_W - 1))
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_QDIV;
                end
                S_QDIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == qlast)
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (ax_reg == 2'd2)
                    begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= S_RDL;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= S_UINIT;
                    end
                end
                S_EMIT:
                begin
                    result_valid_reg <= 1'b1;
                    if ({1'b0, k_reg} == count_reg - 1'b1)
                    begin
                        count_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_RDK;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_LDK:
            begin
                k_atom_reg <= rd_reg;
                coin_reg   <= 1'b0;
                for (int a = 0; a < 3; a++)
                    acc_reg[a] <= '0;
            end
            S_LDL:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    m_reg[a]    <= m_new[a];
                    dneg_reg[a] <= d[a][COORD_W];
                end
                half_reg <= big;
                zz_reg   <= k_atom_reg.ch * rd_reg.ch;
                sum_reg  <= '0;
            end
            S_SQ:
            begin
                sum_reg <= sum_reg + 64'(sqr);
            end
            S_CHK:
            begin
                if (sum_reg == '0)
                    coin_reg <= 1'b1;
                sq_rem_reg <= sum_reg;
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            S_SQRT:
            begin
                if (sq_ge)
                    sq_rem_reg <= sq_rem_reg - sq_try;
                sq_res_reg <= sq_res_new;
                sq_bit_reg <= sq_bit_reg >> 2;
                root_reg   <= sq_res_new[ROOT_W-1:0];
            end
            S_UINIT:
            begin
                un_reg   <= {m_reg[ax_reg], {FRAC_SHIFT{1'b0}}};
                urem_reg <= '0;
                u_reg    <= '0;
            end
            S_UDIV:
            begin
                urem_reg <= uge ? (ut - {1'b0, root_reg}) : ut;
                u_reg    <= {u_reg[U_W-2:0], uge};
                un_reg   <= un_reg << 1;
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(zz_reg) * PROD_W'(u_reg);
                qrem_reg <= '0;
                q_reg    <= '0;
            end
            S_QDIV:
            begin
                // keep the remainder, freeze the quotient once it reaches the cap
                qrem_reg <= qge ? (qt - {1'b0, sum_reg}) : qt;
                prod_reg <= prod_reg << 1;
                if (!q_reg[GRAD_W-1])
                    q_reg <= qn[GRAD_W-1] ? TERM_CAP : qn[GRAD_W-1:0];
            end
            S_ACC:
            begin
                if (dneg_reg[ax_reg])
                    acc_reg[ax_reg] <= acc_reg[ax_reg] + ACC_W'(q_reg);
                else
                    acc_reg[ax_reg] <= acc_reg[ax_reg] - ACC_W'(q_reg);
            end
            S_EMIT:
            begin
                result_reg.atom_index  <= k_reg;
                result_reg.grad_x      <= sat[0];
                result_reg.grad_y      <= sat[1];
                result_reg.grad_z      <= sat[2];
                result_reg.coincident  <= coin_reg;
                result_reg.last_result <= ({1'b0, k_reg} == count_reg - 1'b1);
            end
            default:
            begin
            end
        endcase
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ATOM_DEPTH))
        else $error("atom count beyond memory depth");

    a_emit_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |=> result_valid)
        else $error("emit cycle without result beat");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_result) |-> !busy)
        else $error("still busy after last result");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_result) |-> busy)
        else $error("idle before all results sent");

endmodule
